FILE: hdl/count_sketch_accumulator_top_macros.svh
// Assertion macros shared by the sketch accumulator modules.
`ifndef COUNT_SKETCH_ACCUMULATOR_TOP_MACROS_SVH
`define COUNT_SKETCH_ACCUMULATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CSA_ASSERT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CSA_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CSA_ASSERT(label, clock, resetn, ante, cons)

`define CSA_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

FILE: hdl/csa_pkg.sv
// Shared types and constants for the sketch accumulator.
package csa_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int ACC_WIDTH_DEF   = 48;

    localparam int VALUE_W     = 32;
    localparam int BUCKET_W    = 8;
    localparam int COLUMN_W    = 6;
    localparam int BUCKETS_W   = 9;
    localparam int COLUMNS_W   = 7;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BUCKETS_W-1:0] BUCKETS_RESET = 9'd256;
    localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 7'd64;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BUCKETS = 1'b0,
        CFG_COLUMNS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                       is_read;
        logic                       negate;
        logic signed [VALUE_W-1:0]  value;
    } queue_item_t;

endpackage

FILE: hdl/csa_front.sv
// Front end: configuration registers, range check and table address of each item.
module csa_front #(
    parameter int MAX_BUCKETS = csa_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_COLUMNS = csa_pkg::MAX_COLUMNS_DEF,
    parameter int ADDR_W      = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                opcode,
    input  logic [csa_pkg::BUCKET_W-1:0]        bucket,
    input  logic [csa_pkg::COLUMN_W-1:0]        column,
    input  logic                                negate,
    input  logic signed [csa_pkg::VALUE_W-1:0]  value,
    input  logic                                cfg_write,
    input  logic [csa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                push,
    output csa_pkg::queue_item_t                item,
    output logic [ADDR_W-1:0]                   addr
);
    import csa_pkg::*;

    logic [BUCKETS_W-1:0] buckets_reg;
    logic [COLUMNS_W-1:0] columns_reg;
    logic                 in_range;
    logic [31:0]          addr_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buckets_reg <= BUCKETS_RESET;
            columns_reg <= COLUMNS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BUCKETS: buckets_reg <= cfg_data[BUCKETS_W-1:0];
                CFG_COLUMNS: columns_reg <= cfg_data[COLUMNS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        in_range = (BUCKETS_W'(bucket) < buckets_reg)
                && (32'(bucket) < 32'(MAX_BUCKETS))
                && (COLUMNS_W'(column) < columns_reg)
                && (32'(column) < 32'(MAX_COLUMNS));
        addr_full    = 32'(bucket) * 32'(MAX_COLUMNS) + 32'(column);
        addr         = addr_full[ADDR_W-1:0];
        push         = accept && in_range;
        item.is_read = (opcode == OP_READ);
        item.negate  = negate;
        item.value   = value;
    end

endmodule

FILE: hdl/csa_queue.sv
// Short first-in first-out queue between the front end and the table engine.
`include "count_sketch_accumulator_top_macros.svh"

module csa_queue #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    import csa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = slot_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    `CSA_ASSERT(a_no_overflow, clk, rst_n, push, !full || pop)
    `CSA_ASSERT(a_no_underflow, clk, rst_n, pop, !empty)
    `CSA_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

FILE: hdl/csa_back.sv
// Table engine: clearing pass, read-modify-write with saturation, and read-and-clear.
`include "count_sketch_accumulator_top_macros.svh"

module csa_back #(
    parameter int DEPTH     = 16384,
    parameter int ADDR_W    = 14,
    parameter int ACC_WIDTH = csa_pkg::ACC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  csa_pkg::queue_item_t         head_item,
    input  logic [ADDR_W-1:0]            head_addr,
    output logic                         pop,
    output logic                         clearing,
    output logic                         done,
    output logic signed [ACC_WIDTH-1:0]  sum_value
);
    import csa_pkg::*;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } back_state_t;

    back_state_t                  state_reg;
    logic [ADDR_W-1:0]            clr_cnt_reg;
    queue_item_t                  item_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic                         done_reg;
    logic signed [ACC_WIDTH-1:0]  sum_reg;
    logic signed [ACC_WIDTH-1:0]  rd_data_reg;
    logic signed [ACC_WIDTH-1:0]  table_mem [DEPTH];

    logic signed [VALUE_W:0]      delta;
    logic signed [ACC_WIDTH:0]    sum_wide;
    logic signed [ACC_WIDTH-1:0]  sat_sum;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic signed [ACC_WIDTH-1:0]  wr_data;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign clearing = (state_reg == B_CLEAR);

    always_comb
    begin
        delta    = $signed({item_reg.value[VALUE_W-1], item_reg.value});
        if (item_reg.negate)
        begin
            delta = -delta;
        end
        sum_wide = (ACC_WIDTH+1)'(rd_data_reg) + (ACC_WIDTH+1)'(delta);
        if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1])
        begin
            sat_sum = sum_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            sat_sum = sum_wide[ACC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        case (state_reg)
            B_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            B_EXEC:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg.is_read ? '0 : sat_sum;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        state_reg <= B_EXEC;
                    end
                end
                B_EXEC:
                begin
                    done_reg  <= item_reg.is_read;
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
            addr_reg <= head_addr;
        end
        if (state_reg == B_EXEC)
        begin
            sum_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= table_mem[head_addr];
        end
    end

    assign done      = done_reg;
    assign sum_value = sum_reg;

    `CSA_ASSERT(a_no_pop_in_clear, clk, rst_n, state_reg == B_CLEAR, !pop)
    `CSA_ASSERT_NEXT(a_exec_after_pop, clk, rst_n, pop, state_reg == B_EXEC)
    `CSA_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `CSA_ASSERT(a_done_from_exec, clk, rst_n, done_reg, $past(state_reg == B_EXEC))

endmodule

FILE: hdl/count_sketch_accumulator_top.sv
// Top level of the count sketch accumulator: front end, item queue and table engine.
// After reset the block clears its MAX_BUCKETS x MAX_COLUMNS table one entry per cycle
// and holds busy high until that is done. An item is taken when start is high and busy
// is low; the front end checks its bucket and column against the configured limits and
// drops it if either is out of range, so such an item gives no result. Accepted items
// wait in a four-entry queue, and the table engine, built on a single-port table memory,
// handles each in turn: B_IDLE reads the accumulator as it pops the item, then B_EXEC
// adds or clears it and writes it back. Items can be started on back-to-back cycles
// until the queue fills; the engine starts each item only after writing back the last.
// A read item returns the old accumulator on sum_value with done high for one cycle,
// after the queue, B_IDLE and B_EXEC, and results always leave in item order.
// The receiver cannot hold a result off: sum_value is valid only while done is high.
module count_sketch_accumulator_top #(
    parameter int MAX_BUCKETS = csa_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_COLUMNS = csa_pkg::MAX_COLUMNS_DEF,
    parameter int ACC_WIDTH   = csa_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [csa_pkg::BUCKET_W-1:0]        bucket,
    input  logic [csa_pkg::COLUMN_W-1:0]        column,
    input  logic                                negate,
    input  logic signed [csa_pkg::VALUE_W-1:0]  value,
    input  logic                                cfg_write,
    input  logic [csa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output logic signed [ACC_WIDTH-1:0]         sum_value
);
    import csa_pkg::*;

    localparam int DEPTH   = MAX_BUCKETS * MAX_COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = ADDR_W + $bits(queue_item_t);

    logic                accept;
    logic                push;
    queue_item_t         front_item;
    logic [ADDR_W-1:0]   front_addr;
    logic [ENTRY_W-1:0]  head_entry;
    logic                empty;
    logic                full;
    logic                pop;
    logic                clearing;
    queue_item_t         head_item;
    logic [ADDR_W-1:0]   head_addr;

    assign busy   = clearing || full;
    assign accept = start && !busy;

    csa_front #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .bucket    (bucket),
        .column    (column),
        .negate    (negate),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (front_item),
        .addr      (front_addr)
    );

    csa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_addr, front_item}),
        .pop       (pop),
        .head_data (head_entry),
        .empty     (empty),
        .full      (full)
    );

    assign head_addr = head_entry[ENTRY_W-1 -: ADDR_W];
    assign head_item = head_entry[$bits(queue_item_t)-1:0];

    csa_back #(
        .DEPTH     (DEPTH),
        .ADDR_W    (ADDR_W),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head_item (head_item),
        .head_addr (head_addr),
        .pop       (pop),
        .clearing  (clearing),
        .done      (done),
        .sum_value (sum_value)
    );

endmodule

FILE: test/count_sketch_checker.sv
// Checker for the sketch accumulator: predicts read results from the observed items and compares.
`timescale 1ns / 100ps

module count_sketch_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic                                    opcode,
    input  logic [csa_pkg::BUCKET_W-1:0]            bucket,
    input  logic [csa_pkg::COLUMN_W-1:0]            column,
    input  logic                                    negate,
    input  logic signed [csa_pkg::VALUE_W-1:0]      value,
    input  logic                                    cfg_write,
    input  logic [csa_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    done,
    input  logic signed [csa_pkg::ACC_WIDTH_DEF-1:0] sum_value,
    output int                                      mismatch_count,
    output int                                      pending_results,
    output int                                      results_checked
);
    import csa_pkg::*;

    localparam int TABLE_DEPTH = MAX_BUCKETS_DEF * MAX_COLUMNS_DEF;
    localparam int ACC_W = ACC_WIDTH_DEF;
    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        logic [BUCKET_W-1:0]      bucket;
        logic [COLUMN_W-1:0]      column;
        logic signed [ACC_W-1:0]  sum;
    } read_expect_t;

    logic signed [ACC_W-1:0] sketch_acc [TABLE_DEPTH];
    logic [BUCKETS_W-1:0]    buckets_limit;
    logic [COLUMNS_W-1:0]    columns_limit;
    read_expect_t            expected_sums [$];
    int                      fails;
    int                      checked;

    function automatic logic signed [ACC_W-1:0] saturating_sum(
        input logic signed [ACC_W-1:0]   acc,
        input logic                      neg,
        input logic signed [VALUE_W-1:0] element
    );
        longint base;
        longint delta;
        longint total;
        base = longint'(acc);
        delta = longint'(element);
        if (neg)
        begin
            delta = -delta;
        end
        total = base + delta;
        if (total > ACC_MAX)
        begin
            total = ACC_MAX;
        end
        else if (total < ACC_MIN)
        begin
            total = ACC_MIN;
        end
        return total[ACC_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        read_expect_t           head;
        logic [13:0]            idx;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                sketch_acc[i] = '0;
            end
            buckets_limit = BUCKETS_RESET;
            columns_limit = COLUMNS_RESET;
            expected_sums.delete();
            fails = 0;
            checked = 0;
            mismatch_count <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with no read pending",
                                              sum_value));
                end
                else
                begin
                    head = expected_sums.pop_front();
                    checked++;
                    if (sum_value !== head.sum)
                    begin
                        report_mismatch($sformatf(
                            "read of bucket %0d column %0d gave %0d, predicted %0d",
                            head.bucket, head.column, sum_value, head.sum));
                    end
                end
            end
            if (start && !busy && BUCKETS_W'(bucket) < buckets_limit
                && COLUMNS_W'(column) < columns_limit)
            begin
                idx = {bucket, column};
                if (opcode == OP_READ)
                begin
                    head.bucket = bucket;
                    head.column = column;
                    head.sum = sketch_acc[idx];
                    expected_sums.push_back(head);
                    sketch_acc[idx] = '0;
                end
                else
                begin
                    sketch_acc[idx] = saturating_sum(sketch_acc[idx], negate, value);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_BUCKETS)
                begin
                    buckets_limit = cfg_data[BUCKETS_W-1:0];
                end
                else
                begin
                    columns_limit = cfg_data[COLUMNS_W-1:0];
                end
            end
            mismatch_count <= fails;
            pending_results <= expected_sums.size();
            results_checked <= checked;
        end
    end

endmodule

FILE: test/testbench.sv
// Testbench top for the sketch accumulator: clock, reset, item stimulus, limit settings and verdict.
`timescale 1ns / 100ps

module testbench;

    import csa_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int PILE_RUN      = 8;
    localparam int DRAIN_LIMIT   = 4000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           opcode;
    logic [BUCKET_W-1:0]            bucket;
    logic [COLUMN_W-1:0]            column;
    logic                           negate;
    logic signed [VALUE_W-1:0]      value;
    logic                           cfg_write;
    logic [CFG_INDEX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;
    logic                           done;
    logic signed [ACC_WIDTH_DEF-1:0] sum_value;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int items_sent;
    int settings_used;
    int cur_buckets;
    int cur_columns;
    bit idling_on;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    count_sketch_accumulator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .bucket    (bucket),
        .column    (column),
        .negate    (negate),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .sum_value (sum_value)
    );

    count_sketch_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .bucket          (bucket),
        .column          (column),
        .negate          (negate),
        .value           (value),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .sum_value       (sum_value),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    task automatic send_item(
        input opcode_t              op,
        input logic [BUCKET_W-1:0]  b,
        input logic [COLUMN_W-1:0]  c,
        input logic                 neg,
        input logic [VALUE_W-1:0]   val
    );
        start <= 1'b1;
        opcode <= op;
        bucket <= b;
        column <= c;
        negate <= neg;
        value <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 99) < 12)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] b_data,
                              input logic [CFG_DATA_W-1:0] c_data);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BUCKETS;
        cfg_data <= b_data;
        @(posedge clk);
        cfg_index <= CFG_COLUMNS;
        cfg_data <= c_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_buckets = int'(b_data[BUCKETS_W-1:0]);
        cur_columns = int'(c_data[COLUMNS_W-1:0]);
        settings_used++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int small_v;
        small_v = $urandom_range(0, 511);
        small_v -= 256;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return small_v;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $signed($urandom) >>> $urandom_range(4, 24);
        endcase
    endfunction

    task automatic random_phase(input int count, input int pause_at);
        int                  eff_b;
        int                  eff_c;
        int                  hot_b;
        int                  hot_c;
        int                  r;
        logic [BUCKET_W-1:0] b;
        logic [COLUMN_W-1:0] c;
        opcode_t             op;
        eff_b = (cur_buckets > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF : cur_buckets;
        eff_c = (cur_columns > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cur_columns;
        hot_b = (eff_b > 0) ? $urandom_range(0, eff_b - 1) : 0;
        hot_c = (eff_c > 0) ? $urandom_range(0, eff_c - 1) : 0;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
            begin
                wait_results();
            end
            r = $urandom_range(0, 99);
            if (r < 75 && eff_b > 0 && eff_c > 0)
            begin
                b = BUCKET_W'((hot_b + $urandom_range(0, 3)) % eff_b);
                c = COLUMN_W'((hot_c + $urandom_range(0, 3)) % eff_c);
            end
            else if (r < 90 || (eff_b == MAX_BUCKETS_DEF && eff_c == MAX_COLUMNS_DEF))
            begin
                b = BUCKET_W'($urandom);
                c = COLUMN_W'($urandom);
            end
            else if (eff_b < MAX_BUCKETS_DEF)
            begin
                b = BUCKET_W'($urandom_range(eff_b, MAX_BUCKETS_DEF - 1));
                c = COLUMN_W'($urandom);
            end
            else
            begin
                b = BUCKET_W'($urandom);
                c = COLUMN_W'($urandom_range(eff_c, MAX_COLUMNS_DEF - 1));
            end
            op = ($urandom_range(0, 99) < 25) ? OP_READ : OP_ACCUM;
            send_item(op, b, c, 1'($urandom_range(0, 1)), pick_value());
            maybe_idle();
        end
    endtask

    initial
    begin : stimulus
        int wait_cycles;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= OP_ACCUM;
        bucket <= '0;
        column <= '0;
        negate <= 1'b0;
        value <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_BUCKETS;
        cfg_data <= '0;
        idling_on = 1'b1;
        items_sent = 0;
        settings_used = 1;
        cur_buckets = int'(BUCKETS_RESET);
        cur_columns = int'(COLUMNS_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset limits, then with narrow and disabled ranges.
        send_item(OP_ACCUM, 8'd0, 6'd0, 1'b0, 32'h7FFF_FFFF);
        send_item(OP_ACCUM, 8'd0, 6'd0, 1'b1, 32'h8000_0000);
        send_item(OP_READ, 8'd0, 6'd0, 1'b0, 32'h0000_0000);
        send_item(OP_READ, 8'd0, 6'd0, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_ACCUM, 8'd255, 6'd63, 1'b0, 32'h8000_0000);
        send_item(OP_ACCUM, 8'd255, 6'd63, 1'b1, 32'h0000_0001);
        send_item(OP_READ, 8'd255, 6'd63, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_ACCUM, 8'd170, 6'd42, 1'b0, 32'h0001_0000);
        send_item(OP_ACCUM, 8'd170, 6'd42, 1'b1, 32'h0000_8000);
        send_item(OP_ACCUM, 8'd170, 6'd42, 1'b0, 32'h0000_0000);
        send_item(OP_READ, 8'd170, 6'd42, 1'b0, 32'h5555_5555);
        send_item(OP_ACCUM, 8'd85, 6'd21, 1'b0, 32'h1234_5678);
        send_item(OP_ACCUM, 8'd85, 6'd21, 1'b1, 32'h0FED_CBA9);
        send_item(OP_ACCUM, 8'd85, 6'd21, 1'b0, 32'hFFFF_0000);
        send_item(OP_READ, 8'd85, 6'd21, 1'b0, 32'h0000_0000);
        send_item(OP_ACCUM, 8'd85, 6'd21, 1'b1, 32'h7FFF_FFFF);
        send_item(OP_READ, 8'd85, 6'd21, 1'b0, 32'h0000_0000);
        send_item(OP_READ, 8'd128, 6'd21, 1'b0, 32'h0000_0000);
        set_limits(9'd1, 9'd1);
        send_item(OP_ACCUM, 8'd1, 6'd0, 1'b0, 32'h0000_0005);
        send_item(OP_ACCUM, 8'd0, 6'd1, 1'b0, 32'h0000_0007);
        send_item(OP_ACCUM, 8'd0, 6'd0, 1'b0, 32'h0000_0003);
        send_item(OP_READ, 8'd1, 6'd0, 1'b0, 32'h0000_0000);
        send_item(OP_READ, 8'd0, 6'd0, 1'b0, 32'h0000_0000);
        set_limits(9'd0, 9'h1C0);
        send_item(OP_ACCUM, 8'd0, 6'd0, 1'b0, 32'h0000_0009);
        send_item(OP_READ, 8'd0, 6'd0, 1'b0, 32'h0000_0000);

        // Largest magnitudes piled back to back on one entry, in both directions.
        set_limits(9'd256, 9'd64);
        for (int n = 0; n < PILE_RUN; n++)
        begin
            send_item(OP_ACCUM, 8'd9, 6'd9, 1'b1, 32'h8000_0000);
        end
        send_item(OP_ACCUM, 8'd9, 6'd9, 1'b1, 32'h0000_0001);
        send_item(OP_READ, 8'd9, 6'd9, 1'b0, 32'h0000_0000);
        for (int n = 0; n < PILE_RUN; n++)
        begin
            send_item(OP_ACCUM, 8'd250, 6'd60, 1'b0, 32'h8000_0000);
        end
        send_item(OP_READ, 8'd250, 6'd60, 1'b0, 32'h0000_0000);

        set_limits(9'd256, {2'($urandom_range(0, 3)), 7'd64});
        random_phase(300, -1);
        set_limits(9'd1, 9'd1);
        random_phase(300, -1);
        set_limits(9'd511, 9'd127);
        random_phase(300, -1);
        set_limits(9'd0, 9'd64);
        random_phase(60, -1);
        set_limits(9'd256, 9'h180);
        random_phase(60, -1);
        set_limits(CFG_DATA_W'($urandom_range(1, 256)),
                   {2'($urandom_range(0, 3)), 7'($urandom_range(1, 64))});
        random_phase(300, 150);
        idling_on = 1'b0;
        set_limits(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        random_phase(300, -1);
        set_limits(9'd128, 9'd32);
        random_phase(300, -1);

        start <= 1'b0;
        wait_cycles = 0;
        @(posedge clk);
        while (pending_results != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results != 0)
        begin
            $display("%0d predicted read results never arrived", pending_results);
        end
        $display("Summary: %0d items accepted under %0d limit settings, %0d reads compared.",
                 items_sent, settings_used, results_checked);
        $display("Covered value extremes, both signs, repeated hits and empty ranges.");
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/csa_pkg.sv
hdl/csa_front.sv
hdl/csa_queue.sv
hdl/csa_back.sv
hdl/count_sketch_accumulator_top.sv
test/count_sketch_checker.sv
test/testbench.sv
